// ===== rtl/core/hlq_pkg.sv =====
// Shared types, widths and register codes for the hysteresis level quantizer.
// Used by hlq_cfg, hlq_step, hysteresis_level_quantizer, quantizer_checker and testbench; depends on nothing.
package hlq_pkg;

  localparam int THR_W           = 16;  // one threshold entry
  localparam int NUM_THR         = 4;   // entries packed in one table register
  localparam int TBL_W           = THR_W * NUM_THR;
  localparam int IDX_W           = 2;   // index into a table
  localparam int LVL_W           = 3;   // level, 0..count
  localparam int SMP_W           = 16;  // sample port
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = TBL_W;
  localparam int MAX_LEVELS_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RISING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT    = 3'd3;

  // Configuration as seen by the datapath; count is already clamped.
  typedef struct packed {
    logic [TBL_W-1:0] rise;
    logic [TBL_W-1:0] fall;
    logic [LVL_W-1:0] count;
    logic             init_dir;
    logic             reload;
  } cfg_t;

  function automatic logic [THR_W-1:0] thr_entry(input logic [TBL_W-1:0] tbl,
                                                 input logic [IDX_W-1:0] idx);
    return tbl[{idx, 4'b0000} +: THR_W];
  endfunction

endpackage

// ===== rtl/core/hlq_cfg.sv =====
// Configuration registers of the hysteresis level quantizer, with count clamping
// and a one-cycle reload pulse after every write to a defined register. Depends on hlq_pkg.
module hlq_cfg #(
  parameter int MAX_LEVELS = hlq_pkg::MAX_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hlq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hlq_pkg::cfg_t                  cfg
);

  logic [hlq_pkg::TBL_W-1:0] rise_r, rise_nxt;
  logic [hlq_pkg::TBL_W-1:0] fall_r, fall_nxt;
  logic [hlq_pkg::LVL_W-1:0] count_r, count_nxt;
  logic                      init_r, init_nxt;
  logic                      reload_r, reload_nxt;

  always_comb begin
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    count_nxt  = count_r;
    init_nxt   = init_r;
    reload_nxt = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        hlq_pkg::REG_RISING: begin
          rise_nxt   = cfg_wdata;
          reload_nxt = 1'b1;
        end
        hlq_pkg::REG_FALLING: begin
          fall_nxt   = cfg_wdata;
          reload_nxt = 1'b1;
        end
        hlq_pkg::REG_COUNT: begin
          count_nxt  = cfg_wdata[hlq_pkg::LVL_W-1:0];
          reload_nxt = 1'b1;
        end
        hlq_pkg::REG_INIT: begin
          init_nxt   = cfg_wdata[0];
          reload_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r   <= '0;
      fall_r   <= '0;
      count_r  <= hlq_pkg::LVL_W'(4);
      init_r   <= 1'b0;
      reload_r <= 1'b0;
    end else begin
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      count_r  <= count_nxt;
      init_r   <= init_nxt;
      reload_r <= reload_nxt;
    end
  end

  // A count of zero acts as one; anything above the maximum acts as the maximum.
  always_comb begin
    cfg.rise     = rise_r;
    cfg.fall     = fall_r;
    cfg.init_dir = init_r;
    cfg.reload   = reload_r;
    if (count_r == '0) begin
      cfg.count = hlq_pkg::LVL_W'(1);
    end else if (count_r > hlq_pkg::LVL_W'(MAX_LEVELS)) begin
      cfg.count = hlq_pkg::LVL_W'(MAX_LEVELS);
    end else begin
      cfg.count = count_r;
    end
  end

endmodule

// ===== rtl/core/hlq_step.sv =====
// Next-level and next-direction logic for one sample: parallel threshold
// compares, priority pick and the two direction checks. Depends on hlq_pkg.
module hlq_step #(
  parameter int MAX_LEVELS  = hlq_pkg::MAX_LEVELS_DEF,
  parameter int SAMPLE_BITS = hlq_pkg::SAMPLE_BITS_DEF
) (
  input  logic [hlq_pkg::SMP_W-1:0] sample,
  input  logic [hlq_pkg::LVL_W-1:0] level_cur,
  input  logic                      falling_cur,
  input  hlq_pkg::cfg_t             cfg,
  output logic [hlq_pkg::LVL_W-1:0] level_nxt,
  output logic                      falling_nxt
);

  localparam logic [hlq_pkg::SMP_W-1:0] SMP_MASK =
    hlq_pkg::SMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [hlq_pkg::SMP_W-1:0] s;
  logic [hlq_pkg::TBL_W-1:0] tbl;
  logic                      hit;
  logic [hlq_pkg::IDX_W-1:0] hit_idx;
  logic [hlq_pkg::IDX_W-1:0] top_idx;
  logic [hlq_pkg::LVL_W-1:0] lvl;
  logic                      dir;

  always_comb begin
    s   = sample & SMP_MASK;
    tbl = falling_cur ? cfg.fall : cfg.rise;

    // Scan from the top down so the lowest matching entry wins.
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (hlq_pkg::LVL_W'(i) < cfg.count &&
          s < hlq_pkg::thr_entry(tbl, hlq_pkg::IDX_W'(i))) begin
        hit     = 1'b1;
        hit_idx = hlq_pkg::IDX_W'(i);
      end
    end

    // Rising mode may only raise the level, falling mode may only lower it.
    lvl = level_cur;
    if (hit) begin
      if (falling_cur ? ({1'b0, hit_idx} < level_cur) : ({1'b0, hit_idx} > level_cur)) begin
        lvl = {1'b0, hit_idx};
      end
    end

    top_idx = hlq_pkg::IDX_W'(cfg.count - hlq_pkg::LVL_W'(1));
    if (s >= hlq_pkg::thr_entry(tbl, top_idx)) begin
      lvl = cfg.count;
    end

    // The falling check runs first; a flip just made can be undone by the rising check.
    dir = falling_cur;
    if (!dir && lvl != '0 &&
        s < hlq_pkg::thr_entry(cfg.fall, hlq_pkg::IDX_W'(lvl - hlq_pkg::LVL_W'(1)))) begin
      dir = 1'b1;
    end
    if (dir && lvl < cfg.count &&
        s > hlq_pkg::thr_entry(cfg.rise, hlq_pkg::IDX_W'(lvl))) begin
      dir = 1'b0;
    end

    level_nxt   = lvl;
    falling_nxt = dir;
  end

endmodule

// ===== rtl/core/hysteresis_level_quantizer.sv =====
// Hysteresis level quantizer: each sample word yields one result word holding the
// bar level and direction after that sample. A new word is accepted every cycle
// while the receiver takes results. The input register, the combinational level
// update and the result register form two stages. While the result register waits
// on the receiver, the held word stays in the input register and the input stalls.
// The level/direction state is written in the same cycle the result is stored.
// The user must make configuration writes only while the block is idle; the block
// itself does not enforce it. Each write to a defined register reloads the level
// and direction from the new settings in the cycle after they are stored.
// Depends on hlq_pkg, hlq_cfg and hlq_step.
module hysteresis_level_quantizer #(
  parameter int MAX_LEVELS  = hlq_pkg::MAX_LEVELS_DEF,
  parameter int SAMPLE_BITS = hlq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hlq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hlq_pkg::SMP_W-1:0]      in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hlq_pkg::LVL_W-1:0]      out_level,
  output logic                           out_falling
);

  hlq_pkg::cfg_t cfg;

  logic                      in_valid_r, in_valid_nxt;
  logic [hlq_pkg::SMP_W-1:0] sample_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [hlq_pkg::LVL_W-1:0] out_level_r;
  logic                      out_falling_r;
  logic [hlq_pkg::LVL_W-1:0] level_r, level_nxt;
  logic                      falling_r, falling_nxt;
  logic [hlq_pkg::LVL_W-1:0] step_level;
  logic                      step_falling;
  logic                      advance;
  logic                      in_take;

  hlq_cfg #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  hlq_step #(
    .MAX_LEVELS (MAX_LEVELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step (
    .sample     (sample_r),
    .level_cur  (level_r),
    .falling_cur(falling_r),
    .cfg        (cfg),
    .level_nxt  (step_level),
    .falling_nxt(step_falling)
  );

  // The held word moves to the result register whenever that register is free
  // or is being emptied this cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ready);
    level_nxt     = level_r;
    falling_nxt   = falling_r;
    if (cfg.reload) begin
      falling_nxt = cfg.init_dir;
      level_nxt   = cfg.init_dir ? cfg.count - hlq_pkg::LVL_W'(1) : '0;
    end else if (advance) begin
      level_nxt   = step_level;
      falling_nxt = step_falling;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      falling_r   <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      falling_r   <= falling_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample;
    end
    if (advance) begin
      out_level_r   <= step_level;
      out_falling_r <= step_falling;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_falling = out_falling_r;

  // Unless a reload comes, the stored state matches the word just placed in the result register.
  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg.reload |=> out_level_r == level_r && out_falling_r == falling_r)
    else $error("level state differs from the result just stored");

  // The level never exceeds the largest count.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= hlq_pkg::LVL_W'(MAX_LEVELS))
    else $error("level above the maximum count");

  // A reload leaves the direction chosen by the configuration.
  a_reload_dir: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.reload |=> falling_r == $past(cfg.init_dir))
    else $error("direction not reloaded from configuration");

endmodule

// ===== sim/quantizer_checker.sv =====
// Checker for the hysteresis level quantizer: tracks configuration writes, predicts the
// level/direction word for each accepted sample word and compares result words in order.
// Depends on hlq_pkg.
module quantizer_checker #(
  parameter int MAX_LEVELS = hlq_pkg::MAX_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hlq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [hlq_pkg::SMP_W-1:0]      in_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [hlq_pkg::LVL_W-1:0]      out_level,
  input  logic                           out_falling,
  output int                             errors,
  output int                             pending
);
  import hlq_pkg::*;

  localparam int RESET_COUNT = 4;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             falling;
  } level_word_t;

  logic [TBL_W-1:0] rise_tbl;
  logic [TBL_W-1:0] fall_tbl;
  logic [LVL_W-1:0] count_reg;
  logic             start_falling;
  logic [LVL_W-1:0] bar_level;
  logic             falling_dir;
  level_word_t      expected_levels[$];
  level_word_t      want;
  int               mismatches = 0;

  function automatic int active_levels();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_LEVELS) return MAX_LEVELS;
    return int'(count_reg);
  endfunction

  // A write to any of the four registers puts level and direction back to their starting point.
  function automatic void restart();
    falling_dir = start_falling;
    bar_level   = start_falling ? LVL_W'(active_levels() - 1) : '0;
  endfunction

  function automatic level_word_t quantize(input logic [SMP_W-1:0] s);
    int               n;
    int               lv;
    bit               hit;
    logic [TBL_W-1:0] tbl;
    level_word_t      word;
    n   = active_levels();
    tbl = falling_dir ? fall_tbl : rise_tbl;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!hit && s < tbl[THR_W*i +: THR_W]) begin
        hit = 1'b1;
        // Rising mode may only move the level up, falling mode only down.
        if (falling_dir ? (i < int'(bar_level)) : (i > int'(bar_level)))
          bar_level = LVL_W'(i);
      end
    end
    if (s >= tbl[THR_W*(n-1) +: THR_W]) bar_level = LVL_W'(n);
    lv = int'(bar_level);
    if (!falling_dir && lv > 0 && s < fall_tbl[THR_W*(lv-1) +: THR_W]) falling_dir = 1'b1;
    // A flip to falling just made can be undone by the rising boundary above the level.
    if (falling_dir && lv < n && s > rise_tbl[THR_W*lv +: THR_W]) falling_dir = 1'b0;
    word.level   = bar_level;
    word.falling = falling_dir;
    return word;
  endfunction

  function automatic void flag(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t: %s", $time, msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rise_tbl      = '0;
      fall_tbl      = '0;
      count_reg     = LVL_W'(RESET_COUNT);
      start_falling = 1'b0;
      restart();
      expected_levels.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RISING: begin
            rise_tbl = cfg_wdata;
            restart();
          end
          REG_FALLING: begin
            fall_tbl = cfg_wdata;
            restart();
          end
          REG_COUNT: begin
            count_reg = cfg_wdata[LVL_W-1:0];
            restart();
          end
          REG_INIT: begin
            start_falling = cfg_wdata[0];
            restart();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          flag($sformatf("result word with none expected: level %0d falling %0d",
                         out_level, out_falling));
        end else begin
          want = expected_levels.pop_front();
          if (out_level !== want.level)
            flag($sformatf("level expected %0d, actual %0d", want.level, out_level));
          if (out_falling !== want.falling)
            flag($sformatf("falling expected %0d, actual %0d", want.falling, out_falling));
        end
      end
      if (in_valid && in_ready) expected_levels.push_back(quantize(in_sample));
      pending <= expected_levels.size();
    end
    errors <= mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the hysteresis level quantizer testbench: clock, reset, sample and register
// stimulus, result-side stalls and the verdict.
// Depends on hlq_pkg, hysteresis_level_quantizer and quantizer_checker.
module testbench;
  import hlq_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int LONG_HOLD    = 250;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int SMP_MAX      = (1 << SMP_W) - 1;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_RISING;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic [SMP_W-1:0]      in_sample   = '0;
  logic                  out_ready   = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [LVL_W-1:0]      out_level;
  logic                  out_falling;
  int                    errors;
  int                    pending;

  logic [TBL_W-1:0] cur_rise  = '0;
  logic [TBL_W-1:0] cur_fall  = '0;
  int               walk_pos  = 0;
  int               walk_step = 1;
  int               hold_req  = 0;
  int               hold_seen = 0;
  int               rx_wait   = 0;
  int               calm_left = 0;
  int               rx_roll;
  int               cycles    = 0;

  always #5 clk = ~clk;

  hysteresis_level_quantizer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .out_falling (out_falling)
  );

  quantizer_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .out_falling (out_falling),
    .errors      (errors),
    .pending     (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Walking samples ramp up and down through the thresholds, which is what
  // exercises the hysteresis; the rest sit near a boundary or anywhere.
  function automatic logic [SMP_W-1:0] pick_sample(input bit walking);
    int               r;
    int               v;
    int               k;
    logic [TBL_W-1:0] tbl;
    if (walking) begin
      walk_pos = walk_pos + int'($urandom_range(0, 2 * walk_step)) - walk_step;
      if (walk_pos < 0) walk_pos = 0;
      if (walk_pos > SMP_MAX) walk_pos = SMP_MAX;
      return SMP_W'(walk_pos);
    end
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 55) begin
      tbl = $urandom_range(0, 1) ? cur_rise : cur_fall;
      k   = $urandom_range(0, NUM_THR - 1);
      v   = int'(tbl[THR_W*k +: THR_W]) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > SMP_MAX) v = SMP_MAX;
      return SMP_W'(v);
    end
    return SMP_W'($urandom);
  endfunction

  task automatic send(input logic [SMP_W-1:0] s, input bit burst);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering words and wait until every expected result word has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic new_settings();
    logic [THR_W-1:0]      v [0:NUM_THR-1];
    logic [THR_W-1:0]      t;
    logic [CFG_DATA_W-1:0] data [0:NUM_THR-1];
    logic [CFG_IDX_W-1:0]  order [0:NUM_THR-1];
    int                    kind;
    int                    span;
    int                    lo;
    int                    f;
    int                    start;
    int                    c;
    order = '{REG_RISING, REG_FALLING, REG_COUNT, REG_INIT};
    kind  = $urandom_range(0, 9);
    c     = $urandom_range(0, 2);
    span  = (c == 0) ? 64 : (c == 1) ? 4096 : SMP_MAX + 1;
    lo    = $urandom_range(0, SMP_MAX + 1 - span);
    for (int k = 0; k < NUM_THR; k++) v[k] = THR_W'(lo + int'($urandom_range(0, span - 1)));
    // Mostly ordered boundaries; a few tables stay unordered.
    if (kind < 8) begin
      for (int k = 0; k < NUM_THR - 1; k++)
        for (int j = 0; j < NUM_THR - 1 - k; j++)
          if (v[j] > v[j+1]) begin
            t      = v[j];
            v[j]   = v[j+1];
            v[j+1] = t;
          end
    end
    for (int k = 0; k < NUM_THR; k++) begin
      data[0][THR_W*k +: THR_W] = v[k];
      f = int'(v[k]) - int'($urandom_range(0, span / 8));
      data[1][THR_W*k +: THR_W] = THR_W'((f < 0) ? 0 : f);
    end
    if (kind == 0) begin
      data[0] = '0;
      data[1] = '0;
    end else if (kind == 1) begin
      data[0] = '1;
      data[1] = '1;
    end
    c = $urandom_range(0, 9);
    data[2] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
    data[2][LVL_W-1:0] = (c < 4) ? LVL_W'(MAX_LEVELS_DEF) :
                         (c < 6) ? LVL_W'($urandom_range(1, 3)) : LVL_W'($urandom_range(0, 7));
    data[3] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
    data[3][0] = 1'($urandom_range(0, 1));
    cur_rise  = data[0];
    cur_fall  = data[1];
    walk_pos  = lo + span / 2;
    walk_step = span / 16 + 1;
    start = $urandom_range(0, NUM_THR - 1);
    for (int k = 0; k < NUM_THR; k++)
      write_reg(order[(start + k) % NUM_THR], data[(start + k) % NUM_THR]);
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_INIT + CFG_IDX_W'($urandom_range(1, 4)), {$urandom, $urandom});
    close_writes();
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      rx_wait   = LONG_HOLD;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 3) calm_left = $urandom_range(20, 150);
      if (rx_roll < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_wait = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("hysteresis_level_quantizer verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int phase;
    int n;
    bit burst;
    bit walking;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: all boundaries zero, four levels.
    send(16'h0000, 1'b0);
    send(16'hFFFF, 1'b0);
    drain();

    write_reg(REG_RISING, {16'd4000, 16'd3000, 16'd2000, 16'd1000});
    write_reg(REG_FALLING, {16'd3800, 16'd2800, 16'd1800, 16'd800});
    write_reg(REG_COUNT, 64'd4);
    write_reg(REG_INIT, '0);
    close_writes();
    send(16'd1500, 1'b0);
    send(16'd2500, 1'b0);
    send(16'd1900, 1'b0);
    send(16'd1700, 1'b0);
    send(16'd500, 1'b0);
    send(16'd4500, 1'b0);
    send(16'd3900, 1'b0);
    send(16'd100, 1'b0);
    send(16'd0, 1'b0);
    drain();

    // A write to an unused index must leave level and direction alone.
    write_reg(REG_INIT + CFG_IDX_W'(1), '1);
    close_writes();
    send(16'd2500, 1'b0);
    send(16'hFFFF, 1'b0);
    drain();

    // Zero count behaves as one level; start falling.
    write_reg(REG_COUNT, '0);
    write_reg(REG_INIT, 64'd1);
    close_writes();
    send(16'd0, 1'b0);
    send(16'd900, 1'b0);
    send(16'd1200, 1'b0);
    drain();

    // Count above the maximum is clamped; register data with every bit set.
    write_reg(REG_COUNT, '1);
    write_reg(REG_INIT, '1);
    close_writes();
    send(16'hFFFF, 1'b0);
    send(16'd3000, 1'b0);
    send(16'd0, 1'b0);
    drain();

    write_reg(REG_RISING, '1);
    write_reg(REG_FALLING, '1);
    write_reg(REG_COUNT, 64'd4);
    close_writes();
    send(16'hFFFE, 1'b0);
    send(16'hFFFF, 1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (phase > 0 && $urandom_range(0, 7) == 0) begin
        write_reg(REG_INIT + CFG_IDX_W'($urandom_range(1, 4)), {$urandom, $urandom});
        close_writes();
      end else begin
        new_settings();
      end
      burst   = (phase == 2) || ($urandom_range(0, 3) == 0);
      walking = $urandom_range(0, 1);
      n       = $urandom_range(30, 140);
      for (int k = 0; k < n; k++) begin
        // Back-to-back words against a long result-side hold fill the pipeline.
        if (phase == 2 && k == 10) hold_req <= hold_req + 1;
        send(pick_sample(walking), burst);
      end
      sent += n;
      phase++;
    end
    drain();

    if (errors == 0) begin
      $display("hysteresis_level_quantizer verification clean");
    end else begin
      $display("hysteresis_level_quantizer verification failed");
    end
    $finish;
  end

endmodule
